FILE: src/assert_macros.svh
// Assertion macros for the fuser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define SKF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
// Condition that must never hold outside reset.
`define SKF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition");
`else
`define SKF_ASSERT(lbl, prop)
`define SKF_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: src/skf_pkg.sv
// Package with types, constants and the friction table of the Kalman fuser.
package skf_pkg;

  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned EXP_DEPTH  = 256;
  localparam int unsigned EXP_IDX_W  = $clog2(EXP_DEPTH);
  localparam logic [63:0] EXP_STEP   = (64'd4 << 46) / (64'(EXP_DEPTH) << FRAC_BITS);
  localparam logic [16:0] ONE        = 17'(1 << FRAC_BITS);
  localparam logic [32:0] HALF       = 33'(1 << (FRAC_BITS - 1));
  localparam logic [15:0] R_FLOOR    = 16'd328;
  localparam logic [15:0] PN_RESET   = 16'd164;
  localparam logic [15:0] NAV_RESET  = 16'd32768;
  localparam logic [15:0] MNT_RESET  = 16'd29491;
  localparam logic [15:0] TRF_RESET  = 16'd9830;
  localparam logic [15:0] UNC_RESET  = 16'd16384;

  typedef enum logic [1:0] {
    CH_NONE  = 2'd0,
    CH_NAV   = 2'd1,
    CH_MAINT = 2'd2,
    CH_TRAF  = 2'd3
  } chan_e;

  typedef struct packed {
    chan_e        chan;
    logic [15:0]  r;
    logic [15:0]  z;
    logic [62:0]  stamp;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NOISE, ST_PREP, ST_DIV, ST_MULE, ST_UPDE, ST_UPDU,
    ST_CAP, ST_FRIC, ST_SPD, ST_OUT
  } state_e;

  typedef logic [EXP_DEPTH-1:0][15:0] exp_tab_t;

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // Restoring shift-and-subtract quotient, used only while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= 65'(d)) begin
        rem  = rem - 65'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] q30_exp_neg(logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] r;
    int halvings;
    x = x_in;
    pos = 64'd1 << 30;
    neg = '0;
    term = 64'd1 << 30;
    halvings = 0;
    for (int h = 0; h < 40; h++) begin
      if (x > (64'd1 << 29)) begin
        x = (x + 64'd1) >> 1;
        halvings++;
      end
    end
    for (int k = 1; k < 20; k++) begin
      term = (term * x) >> 30;
      term = udiv64(term, 64'(k));
      if (k[0]) neg = neg + term;
      else pos = pos + term;
    end
    r = (pos > neg) ? pos - neg : 64'd0;
    for (int h = 0; h < 40; h++) begin
      if (h < halvings) r = q30_mul(r, r);
    end
    return r;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] base;
    logic [63:0] cur;
    logic [63:0] rnd;
    rnd  = (64'd1 << (30 - FRAC_BITS)) >> 1;
    base = q30_exp_neg(EXP_STEP);
    cur  = 64'd1 << 30;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      t[i] = 16'((cur + rnd) >> (30 - FRAC_BITS));
      cur  = q30_mul(cur, base);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: src/skf_front.sv
// Front stage: clamps the observation and reduces it to channel, noise and measurement.
module skf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        reliability_i,
  input  logic [15:0]        severity_i,
  input  logic [15:0]        traffic_value_i,
  input  logic               value_present_i,
  input  logic [62:0]        timestamp_i,
  output logic               push_o,
  input  logic               full_i,
  output skf_pkg::item_t     item_o
);

  logic            valid_q;
  skf_pkg::item_t  item_q;
  skf_pkg::item_t  item_d;
  logic [15:0]     rel_c;
  logic [15:0]     sev_c;

  always_comb begin
    rel_c = (reliability_i > 16'(skf_pkg::ONE)) ? 16'(skf_pkg::ONE) : reliability_i;
    sev_c = (severity_i > 16'(skf_pkg::ONE)) ? 16'(skf_pkg::ONE) : severity_i;
    item_d.r     = 16'(skf_pkg::ONE) - rel_c + skf_pkg::R_FLOOR;
    item_d.z     = 16'(skf_pkg::ONE) - sev_c;
    item_d.stamp = timestamp_i;
    unique case (mode_i)
      skf_pkg::CH_NAV:   item_d.chan = skf_pkg::CH_NAV;
      skf_pkg::CH_MAINT: item_d.chan = skf_pkg::CH_MAINT;
      skf_pkg::CH_TRAF: begin
        item_d.chan = value_present_i ? skf_pkg::CH_TRAF : skf_pkg::CH_NONE;
        item_d.z    = traffic_value_i;
      end
      default: item_d.chan = skf_pkg::CH_NONE;
    endcase
  end

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: src/skf_fifo.sv
// Two-entry queue of classified observations between front and back.
module skf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  skf_pkg::item_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output skf_pkg::item_t  data_o
);

  skf_pkg::item_t mem_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/skf_back.sv
// Back sequencer: noise, gain division, estimate update, cap, friction and speed.
`include "assert_macros.svh"
module skf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     noise_i,
  input  logic            empty_i,
  input  skf_pkg::item_t  item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [127:0]    out_data_o
);

  localparam int unsigned EXP_IDX_SUM = 16 + skf_pkg::EXP_IDX_W;

  skf_pkg::state_e state_q, state_d;
  skf_pkg::item_t  it_q;
  logic [15:0]     nav_q, mnt_q, trf_q;
  logic [15:0]     unc_q [3];
  logic [15:0]     u_q, e_q, k_q, cap_q, fric_q;
  logic [16:0]     div_q;
  logic [17:0]     rem_q;
  logic [3:0]      cnt_q;
  logic [32:0]     prod_q;
  logic            out_valid_q;
  logic [127:0]    out_q;

  logic [1:0]      sel;
  logic [16:0]     rounded;
  logic [15:0]     rsat;
  logic [17:0]     trial;
  logic            qbit;
  logic [15:0]     diff;
  logic [15:0]     stp;
  logic [16:0]     usum [3];
  logic [EXP_IDX_SUM-1:0] idx_p;

  assign sel = 2'(it_q.chan) - 2'd1;

  always_comb begin
    rounded = 17'((prod_q + skf_pkg::HALF) >> skf_pkg::FRAC_BITS);
    rsat    = rounded[16] ? 16'hFFFF : rounded[15:0];
    trial   = {rem_q[16:0], (cnt_q == 4'd0) ? u_q[0] : 1'b0};
    qbit    = trial >= 18'(div_q);
    diff    = (it_q.z >= e_q) ? it_q.z - e_q : e_q - it_q.z;
    stp     = rounded[15:0];
    // Table index from the overflow of traffic over the cap that rsat holds in ST_FRIC.
    idx_p   = EXP_IDX_SUM'(trf_q - rsat) * EXP_IDX_SUM'(skf_pkg::EXP_DEPTH);
    for (int i = 0; i < 3; i++) usum[i] = 17'(unc_q[i]) + 17'(noise_i);
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      skf_pkg::ST_IDLE: if (!empty_i) begin
        pop_o   = 1'b1;
        state_d = skf_pkg::ST_NOISE;
      end
      skf_pkg::ST_NOISE:
        state_d = (it_q.chan == skf_pkg::CH_NONE) ? skf_pkg::ST_CAP : skf_pkg::ST_PREP;
      skf_pkg::ST_PREP: state_d = skf_pkg::ST_DIV;
      skf_pkg::ST_DIV:  if (cnt_q == 4'd15) state_d = skf_pkg::ST_MULE;
      skf_pkg::ST_MULE: state_d = skf_pkg::ST_UPDE;
      skf_pkg::ST_UPDE: state_d = skf_pkg::ST_UPDU;
      skf_pkg::ST_UPDU: state_d = skf_pkg::ST_CAP;
      skf_pkg::ST_CAP:  state_d = skf_pkg::ST_FRIC;
      skf_pkg::ST_FRIC: state_d = skf_pkg::ST_SPD;
      skf_pkg::ST_SPD:  state_d = skf_pkg::ST_OUT;
      skf_pkg::ST_OUT:  if (!out_valid_q || out_ready_i) state_d = skf_pkg::ST_IDLE;
      default:          state_d = skf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      nav_q       <= skf_pkg::NAV_RESET;
      mnt_q       <= skf_pkg::MNT_RESET;
      trf_q       <= skf_pkg::TRF_RESET;
      for (int i = 0; i < 3; i++) unc_q[i] <= skf_pkg::UNC_RESET;
    end else begin
      state_q <= state_d;
      if ((state_q == skf_pkg::ST_OUT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        skf_pkg::ST_NOISE:
          for (int i = 0; i < 3; i++) unc_q[i] <= usum[i][16] ? 16'hFFFF : usum[i][15:0];
        skf_pkg::ST_UPDE: begin
          case (it_q.chan)
            skf_pkg::CH_NAV:   nav_q <= (it_q.z >= e_q) ? e_q + stp : e_q - stp;
            skf_pkg::CH_MAINT: mnt_q <= (it_q.z >= e_q) ? e_q + stp : e_q - stp;
            default:           trf_q <= (it_q.z >= e_q) ? e_q + stp : e_q - stp;
          endcase
        end
        skf_pkg::ST_UPDU: unc_q[sel] <= rsat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      skf_pkg::ST_IDLE: it_q <= item_i;
      skf_pkg::ST_PREP: begin
        u_q   <= unc_q[sel];
        e_q   <= (it_q.chan == skf_pkg::CH_NAV) ? nav_q :
                 (it_q.chan == skf_pkg::CH_MAINT) ? mnt_q : trf_q;
        div_q <= 17'(unc_q[sel]) + 17'(it_q.r);
        rem_q <= 18'(unc_q[sel][15:1]);
        cnt_q <= 4'd0;
      end
      skf_pkg::ST_DIV: begin
        rem_q <= qbit ? trial - 18'(div_q) : trial;
        k_q   <= {k_q[14:0], qbit};
        cnt_q <= cnt_q + 4'd1;
      end
      skf_pkg::ST_MULE: prod_q <= 33'(k_q) * 33'(diff);
      skf_pkg::ST_UPDE: prod_q <= 33'(u_q) * 33'(skf_pkg::ONE - 17'(k_q));
      skf_pkg::ST_CAP:  prod_q <= 33'(nav_q) * 33'(mnt_q);
      skf_pkg::ST_FRIC: begin
        cap_q  <= rsat;
        fric_q <= (trf_q > rsat)
          ? skf_pkg::EXP_TAB[idx_p[EXP_IDX_SUM-1:16]]
          : 16'(skf_pkg::ONE);
      end
      skf_pkg::ST_SPD:  prod_q <= 33'(cap_q) * 33'(fric_q);
      skf_pkg::ST_OUT:
        if (!out_valid_q || out_ready_i) out_q <= {1'b0, it_q.stamp, rsat, trf_q, mnt_q, nav_q};
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SKF_ASSERT(a_pop_only_idle, pop_o |-> (state_q == skf_pkg::ST_IDLE))
  `SKF_ASSERT(a_gain_below_one, (state_q == skf_pkg::ST_MULE) |-> (17'(k_q) < skf_pkg::ONE))
  `SKF_ASSERT(a_stall_holds, (out_valid_q && !out_ready_i) |=> out_valid_q)
  `SKF_ASSERT_NEVER(a_div_no_chan, (state_q == skf_pkg::ST_DIV) && (it_q.chan == skf_pkg::CH_NONE))

endmodule

FILE: src/scalar_kalman_three_channel_fuser_top.sv
// Top level of the three-channel scalar Kalman fuser.
// Each accepted observation transaction yields exactly one result transaction carrying the
// three fused Q1.15 estimates, the speed modifier and the observation time. A front stage
// clamps and classifies the observation, a two-entry queue decouples it from the back
// sequencer, and the back sequencer works one observation at a time: it pops the item,
// adds process noise, then for an update sets up the divider, runs the restoring gain
// divider and updates the gain product, estimate and uncertainty, followed by cap,
// friction lookup and speed, and finally loads the output register. An item without
// update skips the set-up, divider and update steps. The front keeps accepting
// while the queue has room, and a finished result waits in the output register without
// holding up the next observation's work until that result is reached. The noise step may
// be written over the configuration channel while the block is idle; it is ready always.
module scalar_kalman_three_channel_fuser_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i,     // noise step
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,   // reliability, severity, traffic_value, timestamp
  input  logic [2:0]    s_axis_tuser,   // mode, value_present
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata    // navigability_est, maintenance_est, traffic_est,
                                        // speed_modifier, last_time
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  skf_pkg::item_t  front_item;
  skf_pkg::item_t  head_item;
  logic [15:0]     noise_q;

  // The configuration channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= skf_pkg::PN_RESET;
    end else if (cfg_valid_i) begin
      noise_q <= cfg_data_i;
    end
  end

  skf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .mode_i          (s_axis_tuser[1:0]),
    .reliability_i   (s_axis_tdata[15:0]),
    .severity_i      (s_axis_tdata[31:16]),
    .traffic_value_i (s_axis_tdata[47:32]),
    .value_present_i (s_axis_tuser[2]),
    .timestamp_i     (s_axis_tdata[110:48]),
    .push_o          (push),
    .full_i          (full),
    .item_o          (front_item)
  );

  skf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_item)
  );

  skf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .noise_i     (noise_q),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
